### rtl/core/date_keyed_min_heap_queue_core_macros.svh
// Assertion macros shared by the date-keyed heap queue checkers.
// Holds only macro definitions; no other file content.
`ifndef DATE_KEYED_MIN_HEAP_QUEUE_CORE_MACROS_SVH
`define DATE_KEYED_MIN_HEAP_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define DKMHQ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DKMHQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/dkmhq_pkg.sv
// Shared types, constants and helpers for the date-keyed heap queue.
// No dependencies; used by the interfaces, controller, datapath, top level, checker and testbench.
`timescale 1ns / 1ps
`default_nettype none

package dkmhq_pkg;

   // Heap sizing.
   localparam int CAPACITY  = 64;
   localparam int ADDR_W    = $clog2(CAPACITY);
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int IDX_W     = ADDR_W + 2;
   localparam int ENTRIES_W = 7;
   localparam int TOTAL_W   = 32;

   // Field widths.
   localparam int ID_W    = 16;
   localparam int YEAR_W  = 12;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int KEY_W   = YEAR_W + MONTH_W + DAY_W;

   // Operation codes of the request beat.
   localparam logic OP_INSERT  = 1'b0;
   localparam logic OP_EXTRACT = 1'b1;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } dkmhq_status_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
   } dkmhq_entry_type;

   typedef struct packed {
      dkmhq_status_type       status;
      dkmhq_entry_type        entry;
      logic [ENTRIES_W-1:0]   entries_held;
      logic [TOTAL_W-1:0]     requests_seen;
   } dkmhq_result_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_UP_CHECK,
      S_UP_CMP,
      S_EXT_READ,
      S_EXT_LOAD,
      S_DN_CHECK,
      S_DN_CMP,
      S_FINISH
   } dkmhq_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic ext_read;
      logic ext_load;
      logic dn_read;
      logic move_up;
      logic move_down;
      logic place;
      logic load_out;
   } dkmhq_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_extract;
      logic full;
      logic empty;
      logic at_root;
      logic leaf;
      logic up_swap;
      logic down_swap;
      logic out_busy;
   } dkmhq_stat_type;

   // Ordering key: year, then month, then day.
   function automatic logic [KEY_W-1:0] key_of(dkmhq_entry_type e);
      return {e.year, e.month, e.day};
   endfunction

endpackage

`default_nettype wire

### rtl/core/dkmhq_if.sv
// Request and response channel interfaces of the date-keyed heap queue.
// Depends on dkmhq_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dkmhq_req_if;
   logic                          valid;
   logic                          ready;
   logic                          operation;
   logic [dkmhq_pkg::ID_W-1:0]    requester_id;
   logic [dkmhq_pkg::YEAR_W-1:0]  req_year;
   logic [dkmhq_pkg::MONTH_W-1:0] req_month;
   logic [dkmhq_pkg::DAY_W-1:0]   req_day;

   modport source (output valid, operation, requester_id, req_year, req_month, req_day,
                   input ready);
   modport sink (input valid, operation, requester_id, req_year, req_month, req_day,
                 output ready);
endinterface

interface dkmhq_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      status;
   logic [dkmhq_pkg::ID_W-1:0]      out_id;
   logic [dkmhq_pkg::YEAR_W-1:0]    out_year;
   logic [dkmhq_pkg::MONTH_W-1:0]   out_month;
   logic [dkmhq_pkg::DAY_W-1:0]     out_day;
   logic [dkmhq_pkg::ENTRIES_W-1:0] entries_held;
   logic [dkmhq_pkg::TOTAL_W-1:0]   requests_seen;

   modport source (output valid, status, out_id, out_year, out_month, out_day,
                   entries_held, requests_seen, input ready);
   modport sink (input valid, status, out_id, out_year, out_month, out_day,
                 entries_held, requests_seen, output ready);
endinterface

`default_nettype wire

### rtl/core/dkmhq_ctrl.sv
// Controller state machine of the date-keyed heap queue.
// Depends on dkmhq_pkg; drives dkmhq_datapath through command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module dkmhq_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  dkmhq_pkg::dkmhq_stat_type stat,
   output dkmhq_pkg::dkmhq_cmd_type  cmd
);
   import dkmhq_pkg::*;

   dkmhq_state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (stat.req_extract) begin
                  state_in = stat.empty ? S_FINISH : S_EXT_READ;
               end else begin
                  state_in = stat.full ? S_FINISH : S_UP_CHECK;
               end
            end
         end
         S_UP_CHECK: state_in = stat.at_root ? S_FINISH : S_UP_CMP;
         S_UP_CMP:   state_in = stat.up_swap ? S_UP_CHECK : S_FINISH;
         S_EXT_READ: state_in = S_EXT_LOAD;
         S_EXT_LOAD: state_in = S_DN_CHECK;
         S_DN_CHECK: state_in = stat.leaf ? S_FINISH : S_DN_CMP;
         S_DN_CMP:   state_in = stat.down_swap ? S_DN_CHECK : S_FINISH;
         S_FINISH:   state_in = stat.out_busy ? S_FINISH : S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // Commands for the current state.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         S_UP_CHECK: begin
            cmd.place = stat.at_root;
         end
         S_UP_CMP: begin
            cmd.move_up = stat.up_swap;
            cmd.place   = !stat.up_swap;
         end
         S_EXT_READ: cmd.ext_read = 1'b1;
         S_EXT_LOAD: cmd.ext_load = 1'b1;
         S_DN_CHECK: begin
            cmd.place   = stat.leaf;
            cmd.dn_read = !stat.leaf;
         end
         S_DN_CMP: begin
            cmd.move_down = stat.down_swap;
            cmd.place     = !stat.down_swap;
         end
         S_FINISH: cmd.load_out = !stat.out_busy;
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/core/dkmhq_datapath.sv
// Datapath of the date-keyed heap queue: heap memory, counters, sift registers
// and the result register. Depends on dkmhq_pkg; commanded by dkmhq_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module dkmhq_datapath (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        in_op,
   input  dkmhq_pkg::dkmhq_entry_type  in_entry,
   input  dkmhq_pkg::dkmhq_cmd_type    cmd,
   output dkmhq_pkg::dkmhq_stat_type   stat,
   input  wire                        rsp_ready,
   output logic                       out_valid,
   output dkmhq_pkg::dkmhq_result_type result
);
   import dkmhq_pkg::*;

   dkmhq_entry_type heap_mem [CAPACITY];

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               out_valid_ff, out_valid_in;
   logic [ADDR_W-1:0]  pos_ff, pos_in;
   dkmhq_entry_type    cur_ff, cur_in;
   dkmhq_entry_type    got_ff, got_in;
   dkmhq_status_type   code_ff, code_in;
   dkmhq_entry_type    rd_a_ff, rd_b_ff;
   dkmhq_result_type   out_ff, out_in;

   logic [IDX_W-1:0]  left_idx, right_idx, cnt_ext;
   logic [ADDR_W-1:0] parent_addr, last_addr, best_addr;
   logic [ADDR_W-1:0] rd_a_addr, rd_b_addr;
   logic              right_ok, pick_right, full, empty, wr_en;
   dkmhq_entry_type   best_entry, wr_data;

   // Neighbor indexes of the current position.
   assign left_idx    = IDX_W'({pos_ff, 1'b1});
   assign right_idx   = left_idx + IDX_W'(1);
   assign cnt_ext     = IDX_W'(count_ff);
   assign parent_addr = (pos_ff - ADDR_W'(1)) >> 1;
   assign last_addr   = ADDR_W'(count_ff - CNT_W'(1));

   // Smaller child; the left one wins a tie.
   assign right_ok   = right_idx < cnt_ext;
   assign pick_right = right_ok && (key_of(rd_b_ff) < key_of(rd_a_ff));
   assign best_entry = pick_right ? rd_b_ff : rd_a_ff;
   assign best_addr  = pick_right ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];

   assign full  = count_ff >= CNT_W'(CAPACITY);
   assign empty = count_ff == '0;

   // Status for the controller.
   always_comb begin
      stat.req_extract = in_op == OP_EXTRACT;
      stat.full        = full;
      stat.empty       = empty;
      stat.at_root     = pos_ff == '0;
      stat.leaf        = left_idx >= cnt_ext;
      stat.up_swap     = key_of(rd_a_ff) > key_of(cur_ff);
      stat.down_swap   = key_of(best_entry) < key_of(cur_ff);
      stat.out_busy    = out_valid_ff && !rsp_ready;
   end

   // Memory port addresses and write data.
   always_comb begin
      rd_a_addr = parent_addr;
      rd_b_addr = right_idx[ADDR_W-1:0];
      if (cmd.ext_read) begin
         rd_a_addr = '0;
         rd_b_addr = last_addr;
      end else if (cmd.dn_read) begin
         rd_a_addr = left_idx[ADDR_W-1:0];
      end
      wr_en   = cmd.move_up || cmd.move_down || cmd.place;
      wr_data = cur_ff;
      if (cmd.move_up) begin
         wr_data = rd_a_ff;
      end else if (cmd.move_down) begin
         wr_data = best_entry;
      end
   end

   // Heap memory: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[pos_ff] <= wr_data;
      end
      rd_a_ff <= heap_mem[rd_a_addr];
      rd_b_ff <= heap_mem[rd_b_addr];
   end

   // Next values of the counters and sift registers.
   always_comb begin
      count_in = count_ff;
      total_in = total_ff;
      pos_in   = pos_ff;
      cur_in   = cur_ff;
      got_in   = got_ff;
      code_in  = code_ff;
      if (cmd.accept) begin
         cur_in  = in_entry;
         got_in  = '0;
         pos_in  = count_ff[ADDR_W-1:0];
         code_in = ST_OK;
         if (in_op == OP_INSERT) begin
            total_in = total_ff + TOTAL_W'(1);
            if (full) begin
               code_in = ST_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end else if (empty) begin
            code_in = ST_EMPTY;
         end
      end
      if (cmd.ext_read) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (cmd.ext_load) begin
         got_in = rd_a_ff;
         cur_in = rd_b_ff;
         pos_in = '0;
      end
      if (cmd.move_up) begin
         pos_in = parent_addr;
      end
      if (cmd.move_down) begin
         pos_in = best_addr;
      end
   end

   // Result register and its valid bit.
   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      if (cmd.load_out) begin
         out_in.status        = code_ff;
         out_in.entry         = got_ff;
         out_in.entries_held  = ENTRIES_W'(count_ff);
         out_in.requests_seen = total_ff;
         out_valid_in         = 1'b1;
      end
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         total_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         total_ff     <= total_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      cur_ff  <= cur_in;
      got_ff  <= got_in;
      code_ff <= code_in;
      out_ff  <= out_in;
   end

   assign out_valid = out_valid_ff;
   assign result    = out_ff;

endmodule

`default_nettype wire

### rtl/core/date_keyed_min_heap_queue_core.sv
// Date-keyed min-heap queue: a 64-entry priority queue ordered by year, month, day.
//
// Channels: req_bus carries one operation per beat (insert with requester id and
// date, or extract earliest); rsp_bus returns exactly one beat per request with a
// status, the extracted entry (zeros unless an extract succeeded), the number of
// entries held and the running count of insert requests. Both use valid/ready;
// a beat moves on a rising clock edge with valid and ready high.
// Sequence: an insert runs an up-check and an up-compare state per heap level the
// entry moves; an extract reads the root and the last entry, loads them, then runs
// a down-check and a down-compare state per level the entry moves (at most 6). Each
// check issues a registered read of the heap memory; each compare compares and writes.
// A full insert or an empty extract goes straight to the finish state. Requests are
// handled one at a time; the next is taken in the cycle after the previous result is
// loaded, even while that response still waits, but its own result then waits too.
// Reset: synchronous, active high; empties the heap and clears the request count.
// Heap memory is not cleared; only written entries are ever used.
// Stall: a held response stays stable; a finished request waits in the
// controller until the response register frees up.
`timescale 1ns / 1ps
`default_nettype none

module date_keyed_min_heap_queue_core (
   input wire          clock,
   input wire          reset,
   dkmhq_req_if.sink   req_bus,
   dkmhq_rsp_if.source rsp_bus
);
   import dkmhq_pkg::*;

   dkmhq_cmd_type    cmd;
   dkmhq_stat_type   stat;
   dkmhq_entry_type  in_entry;
   dkmhq_result_type result;
   logic             out_valid;
   logic             req_ready;

   // Request payload packed as a heap entry.
   assign in_entry.id    = req_bus.requester_id;
   assign in_entry.year  = req_bus.req_year;
   assign in_entry.month = req_bus.req_month;
   assign in_entry.day   = req_bus.req_day;

   dkmhq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dkmhq_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .in_op     (req_bus.operation),
      .in_entry  (in_entry),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_ready (rsp_bus.ready),
      .out_valid (out_valid),
      .result    (result)
   );

   // Channel outputs.
   assign req_bus.ready         = req_ready;
   assign rsp_bus.valid         = out_valid;
   assign rsp_bus.status        = result.status;
   assign rsp_bus.out_id        = result.entry.id;
   assign rsp_bus.out_year      = result.entry.year;
   assign rsp_bus.out_month     = result.entry.month;
   assign rsp_bus.out_day       = result.entry.day;
   assign rsp_bus.entries_held  = result.entries_held;
   assign rsp_bus.requests_seen = result.requests_seen;

endmodule

`default_nettype wire

### rtl/core/dkmhq_checker.sv
// Port-level checker of the date-keyed heap queue, bound to the top level.
// Depends on dkmhq_pkg and date_keyed_min_heap_queue_core_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "date_keyed_min_heap_queue_core_macros.svh"

module dkmhq_checker (
   input wire                               clock,
   input wire                               reset,
   input wire                               rsp_valid,
   input wire                               rsp_ready,
   input wire [1:0]                         rsp_status,
   input wire [dkmhq_pkg::ID_W-1:0]         rsp_out_id,
   input wire [dkmhq_pkg::YEAR_W-1:0]       rsp_out_year,
   input wire [dkmhq_pkg::MONTH_W-1:0]      rsp_out_month,
   input wire [dkmhq_pkg::DAY_W-1:0]        rsp_out_day,
   input wire [dkmhq_pkg::ENTRIES_W-1:0]    rsp_entries_held
);
   import dkmhq_pkg::*;

   // A stalled response beat stays offered.
   `DKMHQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

   // Only a successful extract carries entry data.
   `DKMHQ_ASSERT_IMPLY(a_zero_payload, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_out_id == '0 && rsp_out_year == '0 && rsp_out_month == '0 && rsp_out_day == '0, "nonzero entry on a rejected request")

   // A rejected insert means the heap is at capacity.
   `DKMHQ_ASSERT_IMPLY(a_full_count, clock, reset, rsp_valid && rsp_status == ST_FULL, rsp_entries_held == ENTRIES_W'(CAPACITY), "full status with spare room")

   // An empty extract leaves the heap empty.
   `DKMHQ_ASSERT_IMPLY(a_empty_count, clock, reset, rsp_valid && rsp_status == ST_EMPTY, rsp_entries_held == '0, "empty status with entries held")

endmodule

bind date_keyed_min_heap_queue_core dkmhq_checker u_dkmhq_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_status       (rsp_bus.status),
   .rsp_out_id       (rsp_bus.out_id),
   .rsp_out_year     (rsp_bus.out_year),
   .rsp_out_month    (rsp_bus.out_month),
   .rsp_out_day      (rsp_bus.out_day),
   .rsp_entries_held (rsp_bus.entries_held)
);

`default_nettype wire

### tb/date_keyed_min_heap_queue_core_tb.sv
// Self-checking testbench for the date-keyed min-heap queue core.
// Depends on dkmhq_pkg and the dkmhq_req_if / dkmhq_rsp_if channel interfaces.
// A local heap predictor scores every response beat against its request in order.
`timescale 1ns / 1ps

module date_keyed_min_heap_queue_core_tb;
   import dkmhq_pkg::*;

   localparam int RANDOM_OPS = 1100;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic            op;
      dkmhq_entry_type entry;
   } heap_op_t;

   typedef struct packed {
      dkmhq_status_type     status;
      dkmhq_entry_type      entry;
      logic [ENTRIES_W-1:0] held;
      logic [TOTAL_W-1:0]   seen;
      logic [31:0]          tag;
   } heap_outcome_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Testbench-side drive registers; known from time zero.
   logic     drv_valid = 1'b0;
   heap_op_t drv_op = '0;
   logic     rsp_take = 1'b0;

   heap_op_t      queued_ops[$];
   heap_outcome_t due_responses[$];
   heap_outcome_t next_outcome;
   heap_outcome_t rsp_want;

   // Predictor state.
   dkmhq_entry_type    heap_mem[CAPACITY];
   int unsigned        heap_fill = 0;
   logic [TOTAL_W-1:0] insert_total = '0;

   logic [31:0] cycle_no = '0;
   int          beats_sent = 0;
   int          planned_beats = 0;
   int          tx_idle_pct = 31;
   int          rx_idle_pct = 63;
   int          mismatches = 0;

   dkmhq_req_if req_ch();
   dkmhq_rsp_if rsp_ch();

   assign req_ch.valid        = drv_valid;
   assign req_ch.operation    = drv_op.op;
   assign req_ch.requester_id = drv_op.entry.id;
   assign req_ch.req_year     = drv_op.entry.year;
   assign req_ch.req_month    = drv_op.entry.month;
   assign req_ch.req_day      = drv_op.entry.day;
   assign rsp_ch.ready        = rsp_take;

   date_keyed_min_heap_queue_core u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_no <= cycle_no + 1;
   end

   // True when date a sorts strictly ahead of date b: year, then month, then day.
   function automatic logic date_before(dkmhq_entry_type a, dkmhq_entry_type b);
      return {a.year, a.month, a.day} < {b.year, b.month, b.day};
   endfunction

   // Apply one operation to the predicted heap and return the response it should give.
   function automatic heap_outcome_t heap_apply(heap_op_t req);
      heap_outcome_t   res;
      dkmhq_entry_type tmp;
      int unsigned     pos;
      int unsigned     parent;
      int unsigned     left;
      int unsigned     right;
      int unsigned     best;
      res = '0;
      res.status = ST_OK;
      if (req.op == OP_INSERT) begin
         insert_total = insert_total + 1;
         if (heap_fill >= CAPACITY) begin
            res.status = ST_FULL;
         end else begin
            pos = heap_fill;
            heap_mem[pos] = req.entry;
            heap_fill++;
            // Sift up; an equal parent stops the walk.
            while (pos > 0) begin
               parent = (pos - 1) / 2;
               if (!date_before(heap_mem[pos], heap_mem[parent])) break;
               tmp = heap_mem[parent];
               heap_mem[parent] = heap_mem[pos];
               heap_mem[pos] = tmp;
               pos = parent;
            end
         end
      end else if (heap_fill == 0) begin
         res.status = ST_EMPTY;
      end else begin
         res.entry = heap_mem[0];
         heap_mem[0] = heap_mem[heap_fill - 1];
         heap_fill--;
         pos = 0;
         // Sift down toward the strictly earlier child; the left child wins ties.
         while (pos < heap_fill) begin
            best = pos;
            left = 2 * pos + 1;
            right = 2 * pos + 2;
            if (left < heap_fill && date_before(heap_mem[left], heap_mem[best])) best = left;
            if (right < heap_fill && date_before(heap_mem[right], heap_mem[best])) best = right;
            if (best == pos) break;
            tmp = heap_mem[best];
            heap_mem[best] = heap_mem[pos];
            heap_mem[pos] = tmp;
            pos = best;
         end
      end
      res.held = ENTRIES_W'(heap_fill);
      res.seen = insert_total;
      return res;
   endfunction

   task automatic queue_op(logic op, logic [ID_W-1:0] id, logic [YEAR_W-1:0] year,
                           logic [MONTH_W-1:0] month, logic [DAY_W-1:0] day);
      heap_op_t item;
      item.op = op;
      item.entry.id = id;
      item.entry.year = year;
      item.entry.month = month;
      item.entry.day = day;
      queued_ops.push_back(item);
   endtask

   task automatic queue_extract();
      queue_op(OP_EXTRACT, ID_W'($urandom), YEAR_W'($urandom), MONTH_W'($urandom),
               DAY_W'($urandom));
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   // Request driver: predicts each accepted beat, then offers the next one.
   always @(posedge clock) begin
      if (reset) begin
         drv_valid <= 1'b0;
      end else if (!drv_valid || req_ch.ready) begin
         if (drv_valid) begin
            next_outcome = heap_apply(drv_op);
            next_outcome.tag = cycle_no;
            due_responses.push_back(next_outcome);
            beats_sent++;
         end
         // Idle mix: sender light/receiver heavy, then swapped, then no idling.
         if (beats_sent >= 2 * planned_beats / 3) begin
            tx_idle_pct <= 0;
            rx_idle_pct <= 0;
         end else if (beats_sent >= planned_beats / 3) begin
            tx_idle_pct <= 63;
            rx_idle_pct <= 31;
         end
         if (queued_ops.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
            drv_op <= queued_ops.pop_front();
            drv_valid <= 1'b1;
         end else begin
            drv_valid <= 1'b0;
         end
      end
   end

   // Response monitor: scores each beat against the oldest prediction.
   // A prediction tagged in this same cycle cannot have produced a response yet.
   always @(posedge clock) begin
      if (reset) begin
         rsp_take <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (due_responses.size() == 0 || due_responses[0].tag == cycle_no) begin
               $error("response beat with no request outstanding");
               mismatches++;
            end else begin
               rsp_want = due_responses.pop_front();
               check_field("status", rsp_want.status, rsp_ch.status);
               check_field("out_id", rsp_want.entry.id, rsp_ch.out_id);
               check_field("out_year", rsp_want.entry.year, rsp_ch.out_year);
               check_field("out_month", rsp_want.entry.month, rsp_ch.out_month);
               check_field("out_day", rsp_want.entry.day, rsp_ch.out_day);
               check_field("entries_held", rsp_want.held, rsp_ch.entries_held);
               check_field("requests_seen", rsp_want.seen, rsp_ch.requests_seen);
            end
         end
         rsp_take <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      int unsigned burst_len;
      int unsigned insert_pct;
      int unsigned n;

      // Directed: empty extract, field extremes, date ordering and ties.
      queue_op(OP_EXTRACT, 16'hFFFF, 12'hFFF, 4'hF, 5'h1F);
      queue_op(OP_INSERT, 16'hFFFF, 12'hFFF, 4'd15, 5'd31);
      queue_op(OP_INSERT, 16'h0000, 12'd0, 4'd0, 5'd0);
      queue_op(OP_INSERT, 16'h1234, 12'd2024, 4'd5, 5'd10);
      queue_op(OP_INSERT, 16'h1235, 12'd2024, 4'd5, 5'd10);
      queue_op(OP_INSERT, 16'h1236, 12'd2024, 4'd5, 5'd9);
      queue_op(OP_INSERT, 16'h1237, 12'd2024, 4'd4, 5'd31);
      queue_op(OP_INSERT, 16'h1238, 12'd2023, 4'd12, 5'd31);
      queue_op(OP_INSERT, 16'h1239, 12'd2024, 4'd5, 5'd10);
      queue_op(OP_INSERT, 16'h8000, 12'd13, 4'd0, 5'd0);
      repeat (10) queue_extract();
      queue_op(OP_INSERT, 16'hAAAA, 12'hAAA, 4'd10, 5'd21);
      queue_op(OP_INSERT, 16'h5555, 12'h555, 4'd5, 5'd10);
      repeat (3) queue_extract();

      // Random: fill, drain and mixed bursts so the heap runs full and empty often.
      n = 0;
      while (n < RANDOM_OPS) begin
         burst_len = $urandom_range(20, 100);
         case ($urandom_range(2))
            0: insert_pct = 85;
            1: insert_pct = 15;
            default: insert_pct = 50;
         endcase
         repeat (burst_len) begin
            if ($urandom_range(99) < insert_pct) begin
               // Mostly a narrow date window so ties are common.
               if ($urandom_range(3) == 0)
                  queue_op(OP_INSERT, ID_W'($urandom), YEAR_W'($urandom_range(4095)),
                           MONTH_W'($urandom_range(15)), DAY_W'($urandom_range(31)));
               else
                  queue_op(OP_INSERT, ID_W'($urandom), YEAR_W'(2020 + $urandom_range(2)),
                           MONTH_W'($urandom_range(1, 12)), DAY_W'($urandom_range(1, 4)));
            end else begin
               queue_extract();
            end
            n++;
         end
      end
      planned_beats = queued_ops.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (queued_ops.size() != 0 || drv_valid || due_responses.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && due_responses.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/dkmhq_pkg.sv
rtl/core/dkmhq_if.sv
rtl/core/dkmhq_ctrl.sv
rtl/core/dkmhq_datapath.sv
rtl/core/date_keyed_min_heap_queue_core.sv
rtl/core/dkmhq_checker.sv
tb/date_keyed_min_heap_queue_core_tb.sv
